// ----- rtl/pkrsd_pkg.sv -----
// ----------------------------------------------------------------------------
// pkrsd_pkg
// types and constants of the per-key rate spike detector
// ----------------------------------------------------------------------------
package pkrsd_pkg;

    localparam logic [15:0] DEF_WINDOW = 16'd60;
    localparam logic [15:0] DEF_FLOOR  = 16'd20;
    localparam logic [15:0] RST_FACTOR = 16'd1280;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_FACTOR = 2'd1;
    localparam logic [1:0] REG_FLOOR  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [47:0] bstart;
        logic [47:0] fseen;
        logic [31:0] cur;
        logic [31:0] prev;
        logic [31:0] life;
    } entry_t;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_READ  = 12'b0000_0000_0100,
        S_ROLL  = 12'b0000_0000_1000,
        S_FDIV  = 12'b0000_0001_0000,
        S_WIN   = 12'b0000_0010_0000,
        S_SUM   = 12'b0000_0100_0000,
        S_PREP  = 12'b0000_1000_0000,
        S_RDIV  = 12'b0001_0000_0000,
        S_MULA  = 12'b0010_0000_0000,
        S_MULB  = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } state_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ----- rtl/per_key_rate_spike_detector.sv -----
// ----------------------------------------------------------------------------
// per_key_rate_spike_detector
// input beat to result beat: one read and write back, two 48-step divisions
// on a shared bit-per-cycle divider and six 32x32 partial products
// one item at a time; the next beat is taken the cycle after the result is
// registered; a result that waits on the output holds the item in S_FIN
// after reset a clearing pass zeroes all TABLE_ENTRIES entries before any
// beat is taken; configuration registers reset to 60, 1280 and 20
// ----------------------------------------------------------------------------
module per_key_rate_spike_detector #(
    parameter int TABLE_ENTRIES  = 1024,
    parameter int TIME_FRAC_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key_index[9:0], timestamp[57:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // alert[0], slot_echo[10:1],
                                        // est_count[42:11], rate_q8[82:43]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pkrsd_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SLOT_SH = 10 + IW;
    localparam logic [11:0] SLOT_RCP = 12'(((64'd1 << SLOT_SH) + 64'(TABLE_ENTRIES)
                                            - 64'd1) / 64'(TABLE_ENTRIES));

    logic [15:0] win_reg, factor_reg, floor_reg;
    logic [15:0] wsec, flr;
    logic [31:0] wt;
    logic        cfg_we;

    state_t state_reg, state_next;

    entry_t mem [TABLE_ENTRIES];
    entry_t mem_rd_reg, mem_wd, ent_reg, ent_new;
    logic            mem_we, mem_re;
    logic [IW-1:0]   mem_wa, clr_cnt_reg, slot_in, slot_reg;
    logic [31:0]     slot_full;
    logic [21:0]     slot_prod;
    logic [9:0]      slot_quo;

    logic [9:0]  key_reg;
    logic [47:0] ts_reg;

    logic [47:0] num_reg, quo_reg;
    logic [31:0] rem_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] trial;
    logic        qbit;

    logic [63:0] prod_reg;
    logic [49:0] windowed_reg;
    logic [63:0] htime_reg;
    logic [55:0] a_reg;
    logic        alert0_reg, hzero_reg;
    logic [127:0] acc1_reg, acc2_reg;
    logic [2:0]  step_reg;
    logic [31:0] op_a, op_b;
    logic [127:0] prod_sh;

    logic        out_valid_reg;
    logic [87:0] out_data_reg;

    logic [47:0] el0, el1;
    logic [31:0] e32, nfrac;
    logic [48:0] hdiff;
    logic [31:0] htotal;
    logic [47:0] fh;
    logic        alert_fin;
    logic [33:0] cnt_full;
    logic [31:0] cnt_sat;
    logic [39:0] rate_sat;

    // configuration
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;
    assign wsec   = (win_reg == 16'd0) ? DEF_WINDOW : win_reg;
    assign flr    = (floor_reg == 16'd0) ? DEF_FLOOR : floor_reg;
    assign wt     = 32'({16'd0, wsec} << TIME_FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= DEF_WINDOW;
            factor_reg <= RST_FACTOR;
            floor_reg  <= DEF_FLOOR;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_WINDOW: win_reg    <= pwdata[15:0];
                REG_FACTOR: factor_reg <= pwdata[15:0];
                REG_FLOOR:  floor_reg  <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WINDOW: prdata = {16'd0, win_reg};
            REG_FACTOR: prdata = {16'd0, factor_reg};
            REG_FLOOR:  prdata = {16'd0, floor_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // handshakes
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // key modulo table size by reciprocal multiplication
    assign slot_prod = {12'd0, s_axis_tdata[9:0]} * {10'd0, SLOT_RCP};
    assign slot_quo  = 10'(slot_prod >> SLOT_SH);
    assign slot_full = {22'd0, s_axis_tdata[9:0]}
                     - 32'({22'd0, slot_quo} * 32'(TABLE_ENTRIES));
    assign slot_in   = slot_full[IW-1:0];

    // roll forward on the fetched entry
    always_comb
    begin
        ent_new = mem_rd_reg;
        if (!mem_rd_reg.valid)
        begin
            ent_new = '{valid: 1'b1, bstart: ts_reg, fseen: ts_reg,
                        cur: 32'd0, prev: 32'd0, life: 32'd0};
        end
        el0 = (ts_reg >= ent_new.bstart) ? ts_reg - ent_new.bstart : 48'd0;
        if (el0 >= {15'd0, wt, 1'b0})
        begin
            ent_new.prev   = 32'd0;
            ent_new.cur    = 32'd0;
            ent_new.bstart = ts_reg;
        end
        else if (el0 >= {16'd0, wt})
        begin
            ent_new.prev   = ent_new.cur;
            ent_new.cur    = 32'd0;
            ent_new.bstart = ent_new.bstart + {16'd0, wt};
        end
        ent_new.cur  = sat_inc(ent_new.cur);
        ent_new.life = sat_inc(ent_new.life);
    end

    assign el1   = (ts_reg >= ent_reg.bstart) ? ts_reg - ent_reg.bstart : 48'd0;
    assign e32   = (el1 > {16'd0, wt}) ? wt : el1[31:0];
    assign nfrac = wt - e32;

    // memory
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = slot_reg;
        mem_wd = ent_new;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = '0;
        end
        else if (state_reg == S_READ)
        begin
            mem_we = 1'b1;
        end
    end
    assign mem_re = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[slot_in];
        end
    end

    // shared divider step
    assign trial = {rem_reg, num_reg[47]};
    assign qbit  = (trial >= {1'b0, den_reg});

    // partial product operands
    always_comb
    begin
        case (step_reg)
            3'd0:    begin op_a = windowed_reg[31:0];           op_b = htime_reg[31:0];  end
            3'd1:    begin op_a = windowed_reg[31:0];           op_b = htime_reg[63:32]; end
            3'd2:    begin op_a = {14'd0, windowed_reg[49:32]}; op_b = htime_reg[31:0];  end
            3'd3:    begin op_a = {14'd0, windowed_reg[49:32]}; op_b = htime_reg[63:32]; end
            3'd4:    begin op_a = a_reg[31:0];                  op_b = wt;               end
            default: begin op_a = {8'd0, a_reg[55:32]};         op_b = wt;               end
        endcase
        case (step_reg)
            3'd0, 3'd4: prod_sh = {64'd0, prod_reg};
            3'd3:       prod_sh = {prod_reg, 64'd0};
            default:    prod_sh = {32'd0, prod_reg, 32'd0};
        endcase
    end

    assign hdiff  = {1'b0, ent_reg.bstart} - {1'b0, ent_reg.fseen};
    assign htotal = (ent_reg.life >= ent_reg.cur) ? ent_reg.life - ent_reg.cur : 32'd0;
    assign fh     = {16'd0, factor_reg} * {16'd0, htotal};

    assign alert_fin = alert0_reg & (hzero_reg | (acc1_reg > acc2_reg));
    assign cnt_full  = windowed_reg[49:16];
    assign cnt_sat   = (cnt_full[33:32] != 2'd0) ? 32'hFFFF_FFFF : cnt_full[31:0];
    assign rate_sat  = (quo_reg[47:40] != 8'd0) ? 40'hFF_FFFF_FFFF : quo_reg[39:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_cnt_reg == IW'(TABLE_ENTRIES - 1)) state_next = S_IDLE;
            S_IDLE:  if (s_axis_tvalid) state_next = S_READ;
            S_READ:  state_next = S_ROLL;
            S_ROLL:  state_next = S_FDIV;
            S_FDIV:  if (cnt_reg == 6'd0) state_next = S_WIN;
            S_WIN:   state_next = S_SUM;
            S_SUM:   state_next = S_PREP;
            S_PREP:  state_next = S_RDIV;
            S_RDIV:  if (cnt_reg == 6'd0) state_next = S_MULA;
            S_MULA:  state_next = S_MULB;
            S_MULB:  state_next = (step_reg == 3'd5) ? S_FIN : S_MULA;
            S_FIN:   if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            end
            if (state_reg == S_ROLL || state_reg == S_PREP)
            begin
                cnt_reg <= 6'd47;
            end
            else if (state_reg == S_FDIV || state_reg == S_RDIV)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
            if (state_reg == S_PREP)
            begin
                step_reg <= 3'd0;
            end
            else if (state_reg == S_MULB)
            begin
                step_reg <= step_reg + 3'd1;
            end
            if (state_reg == S_FIN && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            key_reg  <= s_axis_tdata[9:0];
            ts_reg   <= s_axis_tdata[57:10];
            slot_reg <= slot_in;
        end
        if (state_reg == S_READ)
        begin
            ent_reg <= ent_new;
        end
        if (state_reg == S_ROLL)
        begin
            num_reg <= {nfrac, 16'd0};
            den_reg <= wt;
            rem_reg <= 32'd0;
        end
        if (state_reg == S_PREP)
        begin
            num_reg    <= {6'd0, windowed_reg[49:8]};
            den_reg    <= {16'd0, wsec};
            rem_reg    <= 32'd0;
            alert0_reg <= windowed_reg > {18'd0, flr, 16'd0};
            htime_reg  <= {{15{hdiff[48]}}, hdiff};
            hzero_reg  <= (hdiff == 49'd0);
            a_reg      <= {fh, 8'd0};
            acc1_reg   <= '0;
            acc2_reg   <= '0;
        end
        if (state_reg == S_FDIV || state_reg == S_RDIV)
        begin
            rem_reg <= qbit ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            num_reg <= {num_reg[46:0], 1'b0};
            quo_reg <= {quo_reg[46:0], qbit};
        end
        if (state_reg == S_WIN)
        begin
            prod_reg <= ent_reg.prev * {15'd0, quo_reg[16:0]};
        end
        if (state_reg == S_SUM)
        begin
            windowed_reg <= {2'd0, ent_reg.cur, 16'd0} + prod_reg[49:0];
        end
        if (state_reg == S_MULA)
        begin
            prod_reg <= op_a * op_b;
        end
        if (state_reg == S_MULB)
        begin
            if (step_reg < 3'd4)
            begin
                acc1_reg <= acc1_reg + prod_sh;
            end
            else
            begin
                acc2_reg <= acc2_reg + prod_sh;
            end
        end
        if (state_reg == S_FIN && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= {5'd0, rate_sat, cnt_sat, key_reg, alert_fin};
        end
    end

    // checks
    a_mem_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_READ || state_reg == S_CLEAR))
        else $error("table written outside write-back or clearing");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_FIN))
        else $error("result raised without a finished item");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("beat accepted during clearing pass");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the per-key rate spike detector: events go in on
// the stream input in bursts while the output stalls on its own pattern; a
// scoreboard keeps its own slot table and window arithmetic and compares
// every result beat, field by field, against the oldest predicted one
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pkrsd_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;

    class rate_scoreboard;
        logic [15:0] win_reg;
        logic [15:0] factor_reg;
        logic [15:0] floor_reg;
        bit          live [1024];
        logic [47:0] bstart [1024];
        logic [47:0] fseen [1024];
        logic [31:0] cur [1024];
        logic [31:0] prv [1024];
        logic [31:0] life [1024];
        logic [87:0] pending [$];
        int          errors;

        function void init();
            win_reg = DEF_WINDOW;
            factor_reg = RST_FACTOR;
            floor_reg = DEF_FLOOR;
            foreach (live[i]) live[i] = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == REG_WINDOW) win_reg = val;
            else if (idx == REG_FACTOR) factor_reg = val;
            else if (idx == REG_FLOOR) floor_reg = val;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function void note(logic [9:0] key, logic [47:0] ts);
            logic [63:0]  wsec, flr, wt, el, frac, wc, cnt, rate, ht, htot, a;
            logic [127:0] p1, p2;
            bit           al;
            int           s;
            s = key;
            wsec = (win_reg != 0) ? 64'(win_reg) : 64'(DEF_WINDOW);
            flr = (floor_reg != 0) ? 64'(floor_reg) : 64'(DEF_FLOOR);
            wt = wsec << 10;
            if (!live[s])
            begin
                live[s] = 1;
                bstart[s] = ts;
                fseen[s] = ts;
                cur[s] = 0;
                prv[s] = 0;
                life[s] = 0;
            end
            el = (ts >= bstart[s]) ? 64'(ts) - 64'(bstart[s]) : 64'd0;
            if (el >= 2 * wt)
            begin
                prv[s] = 0;
                cur[s] = 0;
                bstart[s] = ts;
            end
            else if (el >= wt)
            begin
                prv[s] = cur[s];
                cur[s] = 0;
                bstart[s] = bstart[s] + wt[47:0];
            end
            cur[s] = bump(cur[s]);
            life[s] = bump(life[s]);
            el = (ts >= bstart[s]) ? 64'(ts) - 64'(bstart[s]) : 64'd0;
            if (el > wt) el = wt;
            frac = ((wt - el) << 16) / wt;
            wc = (64'(cur[s]) << 16) + 64'(prv[s]) * frac;
            al = wc > (flr << 16);
            ht = 64'(bstart[s]) - 64'(fseen[s]);
            htot = (life[s] >= cur[s]) ? 64'(life[s]) - 64'(cur[s]) : 64'd0;
            if (al && ht > 0)
            begin
                a = (64'(factor_reg) * htot) << 8;
                p1 = {64'd0, wc} * {64'd0, ht};
                p2 = {64'd0, a} * {64'd0, wt};
                al = p1 > p2;
            end
            cnt = wc >> 16;
            if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
            rate = wc / (wsec << 8);
            if (rate > 64'hFF_FFFF_FFFF) rate = 64'hFF_FFFF_FFFF;
            pending.push_back({5'd0, rate[39:0], cnt[31:0], key, al});
        endfunction

        function void check(logic [87:0] got);
            logic [87:0] exp_beat;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $realtime, got);
                errors++;
                return;
            end
            exp_beat = pending.pop_front();
            if (got[0] !== exp_beat[0])
            begin
                $display("%0t: alert expected %0d actual %0d", $realtime,
                         exp_beat[0], got[0]);
                errors++;
            end
            if (got[10:1] !== exp_beat[10:1])
            begin
                $display("%0t: slot_echo expected %0d actual %0d", $realtime,
                         exp_beat[10:1], got[10:1]);
                errors++;
            end
            if (got[42:11] !== exp_beat[42:11])
            begin
                $display("%0t: est_count expected %0d actual %0d", $realtime,
                         exp_beat[42:11], got[42:11]);
                errors++;
            end
            if (got[82:43] !== exp_beat[82:43])
            begin
                $display("%0t: rate_q8 expected %0d actual %0d", $realtime,
                         exp_beat[82:43], got[82:43]);
                errors++;
            end
            if (got[87:83] !== 5'd0)
            begin
                $display("%0t: pad bits expected 0 actual %h", $realtime, got[87:83]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // key_index[9:0], timestamp[57:10]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // alert[0], slot_echo[10:1], est_count[42:11],
                                 // rate_q8[82:43]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rate_scoreboard sb;
    int          burst_left;
    int          idle_run;
    bit          hold_req;
    logic [47:0] last_ts [1024];

    per_key_rate_spike_detector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {16'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_event(logic [9:0] key, logic [47:0] ts);
        bit taken;
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {6'd0, ts, key};
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            taken = s_axis_tready;
        end
        sb.note(key, ts);
        last_ts[key] = ts;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_all(logic [15:0] w, logic [15:0] f, logic [15:0] fl);
        drain();
        reg_write(REG_WINDOW, w);
        reg_write(REG_FACTOR, f);
        reg_write(REG_FLOOR, fl);
    endtask

    task automatic random_phase(int n, bit with_hold);
        logic [9:0]  hot [8];
        logic [9:0]  key;
        logic [47:0] ts;
        logic [63:0] wt;
        int          pick;
        wt = ((sb.win_reg != 0) ? 64'(sb.win_reg) : 64'(DEF_WINDOW)) << 10;
        foreach (hot[i]) hot[i] = 10'($urandom_range(0, 1023));
        for (int i = 0; i < n; i++)
        begin
            if (with_hold && i == n / 2) hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                key = hot[$urandom_range(0, 7)];
                if (!sb.live[key]) last_ts[key] = {16'd0, $urandom};
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    ts = last_ts[key] + 48'($urandom_range(0, int'(wt / 16)));
                else if (pick < 85)
                    ts = last_ts[key] + 48'($urandom_range(0, int'(wt + wt / 4)));
                else if (pick < 95)
                    ts = last_ts[key] + 48'($urandom_range(0, int'(3 * wt)));
                else
                    ts = last_ts[key] - 48'($urandom_range(0, int'(wt)));
            end
            else
            begin
                key = 10'($urandom_range(0, 1023));
                ts = 48'({$urandom, $urandom});
            end
            send_event(key, ts);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        burst_left = 0;
        sb = new();
        sb.init();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // defaults, then zero selects the default window and floor
        send_event(10'd0, 48'd0);
        send_event(10'd1023, 48'hFFFF_FFFF_FFFF);
        send_event(10'd1023, 48'd0);
        set_all(16'd0, 16'd0, 16'd0);
        send_event(10'd0, 48'd61440);
        drain();
        reg_write(REG_UNUSED, 16'hFFFF);

        // one-second window, low floor: roll, spike, clear, backward time
        set_all(16'd1, 16'd256, 16'd1);
        send_event(10'd5, 48'd0);
        send_event(10'd5, 48'd100);
        send_event(10'd5, 48'd1024);
        send_event(10'd5, 48'd1500);
        send_event(10'd5, 48'd1600);
        send_event(10'd5, 48'd1700);
        send_event(10'd5, 48'd2100);
        send_event(10'd5, 48'd2200);
        send_event(10'd5, 48'd2300);
        send_event(10'd5, 48'd9000);
        send_event(10'd5, 48'd8000);
        send_event(10'd5, 48'd9100);
        send_event(10'd512, 48'hFFFF_FFFF_F000);
        send_event(10'd512, 48'hFFFF_FFFF_FFFF);
        send_event(10'd341, 48'h5555_5555_5555);
        send_event(10'd682, 48'hAAAA_AAAA_AAAA);

        set_all(16'd60, 16'd1280, 16'd20);
        random_phase(330, 1'b0);
        set_all(16'd1, 16'd128, 16'd2);
        random_phase(330, 1'b1);
        set_all(16'd65535, 16'd65535, 16'd65535);
        random_phase(330, 1'b0);
        set_all(16'd0, 16'd0, 16'd0);
        random_phase(330, 1'b0);
        set_all(16'd3, 16'd1, 16'd1);
        random_phase(330, 1'b0);

        s_axis_tvalid = 1'b0;
        drain();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // output side: check on the rising edge, stall pattern and long hold-off
    initial
    begin
        int cyc;
        int hold_cnt;
        cyc = 0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
            @(negedge clk);
            cyc++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = 600;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready = 1'b0;
            end
            else if ((cyc / 64) % 3 == 0)
                m_axis_tready = 1'b1;
            else
                m_axis_tready = (cyc % 5 != 2) && ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on beats in either direction
    initial
    begin
        idle_run = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
